// File: hw/rtl/antialiased_line_pixel_shader_macros.svh
// Assertion shorthands for the line shader checker.
// All of them sample on clk and are masked while arst_n is low.
`ifndef ANTIALIASED_LINE_PIXEL_SHADER_MACROS_SVH
`define ANTIALIASED_LINE_PIXEL_SHADER_MACROS_SVH

// Same-cycle implication.
`define ALPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ALPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/alps_pkg.sv
package alps_pkg;

	localparam int CFG_IDX_BITS = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_START_X = 3'd0,
		CFG_START_Y = 3'd1,
		CFG_END_X   = 3'd2,
		CFG_END_Y   = 3'd3,
		CFG_SMOOTH  = 3'd4
	} cfg_idx_t;

	// Setup sequencer states
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_SLOPE = 6'b001000,
		ST_PROD  = 6'b010000,
		ST_ICPT  = 6'b100000
	} setup_state_t;

	localparam logic [7:0] RED_FULL = 8'hFF;
	localparam logic [7:0] RED_NONE = 8'h00;

endpackage

// File: hw/rtl/alps_setup.sv
module alps_setup #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [alps_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [COORD_BITS-1:0]                  cfg_data,
	output logic                                   setup_ready,
	output logic                                   smooth_enable,
	output logic                                   axes_swapped,
	output logic [COORD_BITS-1:0]                  span_low,
	output logic [COORD_BITS-1:0]                  span_high,
	output logic signed [FRAC_BITS+1:0]            slope,
	output logic signed [COORD_BITS+FRAC_BITS+1:0] intercept
);

	localparam int C    = COORD_BITS;
	localparam int F    = FRAC_BITS;
	localparam int NB   = C + F;
	localparam int SLW  = F + 2;
	localparam int ICW  = C + F + 2;
	localparam int CNTW = $clog2(NB + 1);

	logic [C-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic         smooth_q;
	alps_pkg::setup_state_t state_q;
	logic         ready_q;

	logic         swap_q, neg_q, zero_q;
	logic [C-1:0] lo_q, hi_q, x0_q, y0_q, dvs_q, rem_q;
	logic [NB-1:0] dq_q;
	logic [CNTW-1:0] cnt_q;
	logic signed [SLW-1:0] slope_q;
	logic signed [ICW-1:0] prod_q, icpt_q;

	logic cfg_hit;
	logic signed [C:0] dx_raw, dy_raw;
	logic [C:0] adx, ady;
	logic steep;
	logic [C-1:0] x0s, y0s, x1s, y1s;
	logic [C-1:0] dx_abs, dy_abs;
	logic dx_neg, dy_neg;
	logic [C:0] trial;
	logic ge;
	logic [C:0] rem_sub;
	logic [SLW-1:0] mag;
	logic signed [ICW:0] prod_full;

	assign cfg_ready = 1'b1;

	always_comb begin
		unique case (cfg_index)
			alps_pkg::CFG_START_X,
			alps_pkg::CFG_START_Y,
			alps_pkg::CFG_END_X,
			alps_pkg::CFG_END_Y,
			alps_pkg::CFG_SMOOTH: cfg_hit = cfg_valid;
			default:              cfg_hit = 1'b0;
		endcase
	end

	// Endpoint deltas, steepness test and axis swap
	always_comb begin
		dx_raw = $signed({1'b0, end_x_q}) - $signed({1'b0, start_x_q});
		dy_raw = $signed({1'b0, end_y_q}) - $signed({1'b0, start_y_q});
		adx    = dx_raw[C] ? (C+1)'(-dx_raw) : (C+1)'(dx_raw);
		ady    = dy_raw[C] ? (C+1)'(-dy_raw) : (C+1)'(dy_raw);
		steep  = adx < ady;
		x0s    = steep ? start_y_q : start_x_q;
		y0s    = steep ? start_x_q : start_y_q;
		x1s    = steep ? end_y_q   : end_x_q;
		y1s    = steep ? end_x_q   : end_y_q;
		dx_abs = steep ? ady[C-1:0] : adx[C-1:0];
		dy_abs = steep ? adx[C-1:0] : ady[C-1:0];
		dx_neg = steep ? dy_raw[C] : dx_raw[C];
		dy_neg = steep ? dx_raw[C] : dy_raw[C];
	end

	// One restoring division step per cycle
	always_comb begin
		trial   = {rem_q, dq_q[NB-1]};
		ge      = trial >= {1'b0, dvs_q};
		rem_sub = trial - {1'b0, dvs_q};
		mag     = {1'b0, dq_q[F:0]};
		prod_full = $signed({1'b0, x0_q}) * slope_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
			smooth_q  <= 1'b0;
			state_q   <= alps_pkg::ST_LOAD;
			ready_q   <= 1'b0;
			cnt_q     <= '0;
		end else if (cfg_hit) begin
			unique case (cfg_index)
				alps_pkg::CFG_START_X: start_x_q <= cfg_data;
				alps_pkg::CFG_START_Y: start_y_q <= cfg_data;
				alps_pkg::CFG_END_X:   end_x_q   <= cfg_data;
				alps_pkg::CFG_END_Y:   end_y_q   <= cfg_data;
				default:               smooth_q  <= cfg_data[0];
			endcase
			// restart the setup on every register write
			state_q <= alps_pkg::ST_LOAD;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				alps_pkg::ST_LOAD: begin
					cnt_q   <= CNTW'(NB);
					state_q <= alps_pkg::ST_DIV;
				end
				alps_pkg::ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						state_q <= alps_pkg::ST_SLOPE;
					end
				end
				alps_pkg::ST_SLOPE: state_q <= alps_pkg::ST_PROD;
				alps_pkg::ST_PROD:  state_q <= alps_pkg::ST_ICPT;
				alps_pkg::ST_ICPT: begin
					ready_q <= 1'b1;
					state_q <= alps_pkg::ST_IDLE;
				end
				default: state_q <= alps_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			alps_pkg::ST_LOAD: begin
				swap_q <= steep;
				x0_q   <= x0s;
				y0_q   <= y0s;
				lo_q   <= (x0s > x1s) ? x1s : x0s;
				hi_q   <= (x0s > x1s) ? x0s : x1s;
				dvs_q  <= dx_abs;
				neg_q  <= dx_neg ^ dy_neg;
				zero_q <= dx_abs == '0;
				rem_q  <= '0;
				dq_q   <= {dy_abs, {F{1'b0}}};
			end
			alps_pkg::ST_DIV: begin
				rem_q <= ge ? rem_sub[C-1:0] : trial[C-1:0];
				dq_q  <= {dq_q[NB-2:0], ge};
			end
			alps_pkg::ST_SLOPE: begin
				// single point line: force slope to zero
				if (zero_q) begin
					slope_q <= '0;
				end else begin
					slope_q <= neg_q ? $signed(-mag) : $signed(mag);
				end
			end
			alps_pkg::ST_PROD: prod_q <= prod_full[ICW-1:0];
			alps_pkg::ST_ICPT: icpt_q <= $signed({2'b00, y0_q, {F{1'b0}}}) - prod_q;
			default: ;
		endcase
	end

	assign setup_ready   = ready_q;
	assign smooth_enable = smooth_q;
	assign axes_swapped  = swap_q;
	assign span_low      = lo_q;
	assign span_high     = hi_q;
	assign slope         = slope_q;
	assign intercept     = icpt_q;

endmodule

// File: hw/rtl/alps_pixel_pipe.sv
module alps_pixel_pipe #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   setup_ready,
	input  logic                                   smooth_enable,
	input  logic                                   axes_swapped,
	input  logic [COORD_BITS-1:0]                  span_low,
	input  logic [COORD_BITS-1:0]                  span_high,
	input  logic signed [FRAC_BITS+1:0]            slope,
	input  logic signed [COORD_BITS+FRAC_BITS+1:0] intercept,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [COORD_BITS-1:0]                  pixel_x,
	input  logic [COORD_BITS-1:0]                  pixel_y,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [7:0]                             red_level
);

	localparam int C   = COORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int PW  = C + F + 3;
	localparam int ICW = C + F + 2;
	localparam int SW  = C + F + 4;
	localparam int LW  = SW - F;

	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [C-1:0] px_s1, py_s1, py_s2;
	logic span_s1, span_s2;
	logic signed [PW-1:0] prod_s2;
	logic on_s3, below_s3, above_s3;
	logic [F-1:0] err_s3;
	logic [7:0] red_s4;

	logic [C-1:0] pxs, pys;
	logic signed [SW-1:0] ideal_h;
	logic signed [LW-1:0] line_y, diff;
	logic [F:0] cov_lo, cov_hi;
	logic [F+8:0] scl_lo, scl_hi;
	logic [7:0] red_nx;

	// Each stage moves when it is empty or the next one moves
	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = setup_ready && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid && in_ready;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: axis swap and span test
	always_comb begin
		pxs = axes_swapped ? pixel_y : pixel_x;
		pys = axes_swapped ? pixel_x : pixel_y;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			px_s1   <= pxs;
			py_s1   <= pys;
			span_s1 <= (pxs >= span_low) && (pxs <= span_high);
		end
	end

	// Stage 2: slope times column
	always_ff @(posedge clk) begin
		if (en2) begin
			prod_s2 <= PW'(slope * $signed({1'b0, px_s1}));
			py_s2   <= py_s1;
			span_s2 <= span_s1;
		end
	end

	// Stage 3: add intercept and half, round, compare rows
	always_comb begin
		ideal_h = $signed({prod_s2[PW-1], prod_s2})
			+ $signed({{2{intercept[ICW-1]}}, intercept})
			+ $signed(SW'(1) << (F - 1));
		line_y  = ideal_h[SW-1:F];
		diff    = $signed({{(LW-C){1'b0}}, py_s2}) - line_y;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			on_s3    <= span_s2 && (diff == LW'(0));
			below_s3 <= span_s2 && (diff == -LW'(1));
			above_s3 <= span_s2 && (diff == LW'(1));
			err_s3   <= ideal_h[F-1:0];
		end
	end

	// Stage 4: coverage scaled by 255, truncated
	always_comb begin
		cov_lo = {1'b1, {F{1'b0}}} - {1'b0, err_s3};
		cov_hi = {1'b0, err_s3};
		scl_lo = {cov_lo, 8'h00} - {8'h00, cov_lo};
		scl_hi = {cov_hi, 8'h00} - {8'h00, cov_hi};
		priority if (on_s3) begin
			red_nx = alps_pkg::RED_FULL;
		end else if (smooth_enable && below_s3) begin
			red_nx = scl_lo[F+7:F];
		end else if (smooth_enable && above_s3) begin
			red_nx = scl_hi[F+7:F];
		end else begin
			red_nx = alps_pkg::RED_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			red_s4 <= red_nx;
		end
	end

	assign out_valid = v_s4;
	assign red_level = red_s4;

endmodule

// File: hw/rtl/antialiased_line_pixel_shader.sv
// Channel     Dir  Payload (low bit up)                      Beat when
// s_axis      in   tdata: pixel_x, pixel_y, zero fill        tvalid && tready
// m_axis      out  tdata: red_level                          tvalid && tready
// cfg         in   cfg_index, cfg_data                       cfg_valid && cfg_ready
//
// One pixel per cycle while m_axis_tready and the setup allow; a pixel passes four register stages.
// After reset and after each register write the setup loads, runs the bit-serial slope divider,
// then forms slope, product and intercept; s_axis_tready stays low meanwhile.
// Stages advance independently, so an output stall only fills the bubbles behind it.
// arst_n clears valid bits, configuration and setup state.
module antialiased_line_pixel_shader #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,   // pixel_x, pixel_y
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [7:0]                            m_axis_tdata,   // red_level
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [alps_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [COORD_BITS-1:0]                 cfg_data
);

	logic setup_ready, smooth_enable, axes_swapped;
	logic [COORD_BITS-1:0] span_low, span_high;
	logic signed [FRAC_BITS+1:0] slope;
	logic signed [COORD_BITS+FRAC_BITS+1:0] intercept;

	alps_setup #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_setup (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.setup_ready  (setup_ready),
		.smooth_enable(smooth_enable),
		.axes_swapped (axes_swapped),
		.span_low     (span_low),
		.span_high    (span_high),
		.slope        (slope),
		.intercept    (intercept)
	);

	alps_pixel_pipe #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.setup_ready  (setup_ready),
		.smooth_enable(smooth_enable),
		.axes_swapped (axes_swapped),
		.span_low     (span_low),
		.span_high    (span_high),
		.slope        (slope),
		.intercept    (intercept),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.pixel_x      (s_axis_tdata[COORD_BITS-1:0]),
		.pixel_y      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.red_level    (m_axis_tdata)
	);

endmodule

// File: hw/rtl/alps_checker.sv
`include "antialiased_line_pixel_shader_macros.svh"

module alps_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_axis_tvalid,
	input logic                                  s_axis_tready,
	input logic                                  m_axis_tvalid,
	input logic                                  m_axis_tready,
	input logic [7:0]                            m_axis_tdata,   // red_level
	input logic                                  cfg_valid,
	input logic                                  cfg_ready,
	input logic [alps_pkg::CFG_IDX_BITS-1:0]     cfg_index
);

	logic s_beat, cfg_hit;

	assign s_beat  = s_axis_tvalid && s_axis_tready;
	assign cfg_hit = cfg_valid && cfg_ready && (
		cfg_index == alps_pkg::CFG_START_X || cfg_index == alps_pkg::CFG_START_Y ||
		cfg_index == alps_pkg::CFG_END_X   || cfg_index == alps_pkg::CFG_END_Y ||
		cfg_index == alps_pkg::CFG_SMOOTH);

	// Stalled result holds
	`ALPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed under stall")

	// A register write forces a new setup before the next pixel
	`ALPS_ASSERT_NEXT(a_cfg_blocks, cfg_hit, !s_axis_tready, "pixel taken before setup rerun")

	// With the sink ready meanwhile, an accepted pixel comes out of the pipeline
	`ALPS_ASSERT_NOW(a_latency, $past(s_beat, 4) && $past(m_axis_tready, 3) && $past(m_axis_tready, 2) && $past(m_axis_tready, 1), m_axis_tvalid, "result missing after pipeline latency")

	// Config writes are never held off
	`ALPS_ASSERT_NOW(a_cfg_always, cfg_valid, cfg_ready, "config port not ready")

endmodule

bind antialiased_line_pixel_shader alps_checker u_alps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.cfg_index    (cfg_index)
);

// File: dv/tb_antialiased_line_pixel_shader.sv
`timescale 1ns / 100ps

module tb_antialiased_line_pixel_shader;

	localparam int COORD_BITS  = 12;
	localparam int FRAC_BITS   = 16;
	localparam int TDATA_BITS  = ((2*COORD_BITS+7)/8)*8;
	localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
	localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
	localparam longint HALF_Q  = longint'(1) << (FRAC_BITS - 1);
	localparam longint COVER_SCALE = 255;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 150;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] x;
	} pixel_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [TDATA_BITS-1:0]      s_axis_tdata = '0;     // pixel_x, pixel_y
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [7:0]                 m_axis_tdata;          // red_level
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [alps_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [COORD_BITS-1:0]      cfg_data = '0;

	antialiased_line_pixel_shader #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the line registers and the derived setup
	logic [COORD_BITS-1:0]      ep_start_x = '0, ep_start_y = '0;
	logic [COORD_BITS-1:0]      ep_end_x = '0, ep_end_y = '0;
	logic                       smooth_on = 1'b0;
	logic                       axes_swapped = 1'b0;
	logic [COORD_BITS-1:0]      span_low = '0, span_high = '0;
	logic signed [FRAC_BITS+1:0] slope_q = '0;
	logic signed [COORD_BITS+FRAC_BITS+1:0] intercept_q = '0;
	logic                       line_ready = 1'b0;

	pixel_t                     pixel_queue[$];
	logic [7:0]                 expected_red[$];
	pixel_t                     next_pixel;
	logic [7:0]                 red_wanted;
	int                         mismatches = 0;
	int                         gap_left = 0;
	int                         stall_left = 0;
	int                         hold_left = 0;
	bit                         hold_req = 0;
	bit                         hold_done = 0;
	bit                         calm = 0;

	function automatic void settle_line();
		longint x0, y0, x1, y1, dx, dy, t;
		if (!line_ready) begin
			x0 = longint'(ep_start_x);
			y0 = longint'(ep_start_y);
			x1 = longint'(ep_end_x);
			y1 = longint'(ep_end_y);
			dx = x1 - x0;
			dy = y1 - y0;
			axes_swapped = ((dx < 0) ? -dx : dx) < ((dy < 0) ? -dy : dy);
			if (axes_swapped) begin
				t = x0; x0 = y0; y0 = t;
				t = x1; x1 = y1; y1 = t;
			end
			dx = x1 - x0;
			dy = y1 - y0;
			// a single point has no x run: keep the slope flat
			slope_q = (FRAC_BITS+2)'((dx == 0) ? longint'(0) : (dy * ONE_Q) / dx);
			intercept_q = (COORD_BITS+FRAC_BITS+2)'(y0 * ONE_Q - x0 * longint'(slope_q));
			span_low = COORD_BITS'((x0 < x1) ? x0 : x1);
			span_high = COORD_BITS'((x0 < x1) ? x1 : x0);
			line_ready = 1'b1;
		end
	endfunction

	// Rounded row of the ideal line at column u, in line space, and its coverage fraction
	function automatic longint line_row(longint u, output longint frac);
		longint ideal;
		settle_line();
		ideal = longint'(slope_q) * u + longint'(intercept_q) + HALF_Q;
		line_row = ideal >>> FRAC_BITS;
		frac = ideal - line_row * ONE_Q;
	endfunction

	function automatic logic [7:0] shade_pixel(pixel_t p);
		longint u, v, row, frac;
		logic [7:0] red;
		settle_line();
		u = longint'(axes_swapped ? p.y : p.x);
		v = longint'(axes_swapped ? p.x : p.y);
		red = alps_pkg::RED_NONE;
		if (u >= longint'(span_low) && u <= longint'(span_high)) begin
			row = line_row(u, frac);
			if (v == row)
				red = alps_pkg::RED_FULL;
			else if (smooth_on && v == row - 1)
				red = 8'((COVER_SCALE * (ONE_Q - frac)) >>> FRAC_BITS);
			else if (smooth_on && v == row + 1)
				red = 8'((COVER_SCALE * frac) >>> FRAC_BITS);
		end
		return red;
	endfunction

	function automatic void flag_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] MISMATCH: %s", $realtime, what);
	endfunction

	function automatic longint clip_coord(longint c);
		if (c < 0)
			return 0;
		if (c > longint'(COORD_MAX))
			return longint'(COORD_MAX);
		return c;
	endfunction

	// Queue the pixel at line-space column u, d rows off the rounded line
	function automatic void queue_near(int u, int d);
		longint v, frac;
		pixel_t p;
		v = clip_coord(line_row(longint'(u), frac) + longint'(d));
		p.x = COORD_BITS'(axes_swapped ? v : longint'(u));
		p.y = COORD_BITS'(axes_swapped ? longint'(u) : v);
		pixel_queue.push_back(p);
	endfunction

	function automatic void queue_pixel(int x, int y);
		pixel_t p;
		p.x = COORD_BITS'(x);
		p.y = COORD_BITS'(y);
		pixel_queue.push_back(p);
	endfunction

	function automatic void queue_random_pixels(int n);
		int lo, hi;
		repeat (n) begin
			if ($urandom_range(0, 4) == 0) begin
				queue_pixel(int'($urandom_range(0, COORD_MAX)),
					int'($urandom_range(0, COORD_MAX)));
			end else begin
				settle_line();
				lo = int'(clip_coord(longint'(span_low) - 2));
				hi = int'(clip_coord(longint'(span_high) + 2));
				queue_near(int'($urandom_range(lo, hi)), int'($urandom_range(0, 4)) - 2);
			end
		end
	endfunction

	function automatic logic [COORD_BITS-1:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return COORD_BITS'(COORD_MAX);
			default: return COORD_BITS'($urandom_range(0, COORD_MAX));
		endcase
	endfunction

	// Mostly independent endpoints, sometimes a short line around the other end
	function automatic logic [COORD_BITS-1:0] pick_end(logic [COORD_BITS-1:0] base);
		if ($urandom_range(0, 2) == 0)
			return COORD_BITS'(clip_coord(longint'(base)
				+ longint'($urandom_range(0, 8)) - 4));
		return pick_coord();
	endfunction

	task automatic write_reg(logic [alps_pkg::CFG_IDX_BITS-1:0] idx,
		logic [COORD_BITS-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			alps_pkg::CFG_START_X: ep_start_x = value;
			alps_pkg::CFG_START_Y: ep_start_y = value;
			alps_pkg::CFG_END_X:   ep_end_x = value;
			alps_pkg::CFG_END_Y:   ep_end_y = value;
			alps_pkg::CFG_SMOOTH:  smooth_on = value[0];
			default: ;
		endcase
		if (idx <= alps_pkg::CFG_SMOOTH)
			line_ready = 1'b0;
	endtask

	task automatic write_line(int sx, int sy, int ex, int ey, int smooth);
		write_reg(alps_pkg::CFG_START_X, COORD_BITS'(sx));
		write_reg(alps_pkg::CFG_START_Y, COORD_BITS'(sy));
		write_reg(alps_pkg::CFG_END_X, COORD_BITS'(ex));
		write_reg(alps_pkg::CFG_END_Y, COORD_BITS'(ey));
		write_reg(alps_pkg::CFG_SMOOTH, COORD_BITS'(smooth));
	endtask

	task automatic write_unused_reg();
		write_reg(alps_pkg::CFG_IDX_BITS'($urandom_range(int'(alps_pkg::CFG_SMOOTH) + 1,
			2**alps_pkg::CFG_IDX_BITS - 1)), COORD_BITS'($urandom_range(0, COORD_MAX)));
	endtask

	task automatic randomize_line();
		logic [COORD_BITS-1:0] sx, sy;
		if ($urandom_range(0, 3) != 0) begin
			sx = pick_coord();
			sy = pick_coord();
			write_reg(alps_pkg::CFG_START_X, sx);
			write_reg(alps_pkg::CFG_START_Y, sy);
			write_reg(alps_pkg::CFG_END_X, pick_end(sx));
			write_reg(alps_pkg::CFG_END_Y, pick_end(sy));
		end else begin
			write_reg(alps_pkg::CFG_IDX_BITS'($urandom_range(int'(alps_pkg::CFG_START_X),
				int'(alps_pkg::CFG_END_Y))), pick_coord());
		end
		if ($urandom_range(0, 1))
			write_reg(alps_pkg::CFG_SMOOTH, COORD_BITS'($urandom_range(0, COORD_MAX)));
		if ($urandom_range(0, 4) == 0)
			write_unused_reg();
	endtask

	// Wait until every queued pixel went in and every red level came back
	task automatic wait_drained();
		do @(posedge clk);
		while (pixel_queue.size() != 0 || s_axis_tvalid || expected_red.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Pixel driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_red.push_back(shade_pixel(pixel_t'(s_axis_tdata[2*COORD_BITS-1:0])));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pixel_queue.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					gap_left <= $urandom_range(0, 9);
					s_axis_tvalid <= 1'b0;
				end else begin
					next_pixel = pixel_queue.pop_front();
					s_axis_tdata <= TDATA_BITS'(next_pixel);
					s_axis_tvalid <= 1'b1;
				end
			end
		end
	end

	// Long output hold-off, so the pipe fills and backs up into s_axis
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
		end
	end

	// Result monitor and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_red.size() == 0) begin
					flag_mismatch($sformatf("red_level %0d with no pixel waiting", m_axis_tdata));
				end else begin
					red_wanted = expected_red.pop_front();
					if (m_axis_tdata !== red_wanted)
						flag_mismatch($sformatf("red_level expected %0d actual %0d",
							red_wanted, m_axis_tdata));
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(0, 9);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset setup: a single point at the origin, smoothing off
		queue_pixel(0, 0);
		queue_pixel(0, 1);
		queue_pixel(1, 0);
		queue_pixel(COORD_MAX, COORD_MAX);
		queue_pixel(COORD_MAX, 0);
		queue_pixel(0, COORD_MAX);
		wait_drained();

		// Shallow line over the full width, both span ends
		write_line(0, 0, COORD_MAX, COORD_MAX / 2, 1);
		queue_near(0, 0);
		queue_near(COORD_MAX / 2, -1);
		queue_near(COORD_MAX / 2, 0);
		queue_near(COORD_MAX / 2, 1);
		queue_near(COORD_MAX, 0);
		queue_near(COORD_MAX, 1);
		wait_drained();

		// Steep, falling line: axes swap
		write_line(COORD_MAX, 0, COORD_MAX - 95, COORD_MAX, 1);
		for (int d = -1; d <= 1; d++) begin
			queue_near(0, d);
			queue_near(1000, d);
		end
		queue_near(COORD_MAX, 0);
		wait_drained();

		// Single point at the far corner, plus a write to an unused index
		write_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
		write_unused_reg();
		queue_near(COORD_MAX, -1);
		queue_near(COORD_MAX, 0);
		queue_pixel(COORD_MAX - 1, COORD_MAX);
		wait_drained();

		for (int phase = 0; phase < 24; phase++) begin
			randomize_line();
			if (phase >= 21)
				calm = 1;
			if (phase == 3) begin
				queue_random_pixels(250);
				hold_req = 1;
			end else begin
				queue_random_pixels(35);
			end
			wait_drained();
		end

		if (mismatches == 0 && expected_red.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
